// ===== hdl/mwm_pkg.sv =====
package mwm_pkg;

    // default grid bounds, handed to the top level parameters
    localparam int MAX_WIDTH_DEF  = 16;
    localparam int MAX_HEIGHT_DEF = 16;

    // coordinates and sizes inside the block, wide enough for a 64 x 64 grid plus one
    localparam int COORD_W = 7;
    localparam int SIZE_W  = 5;
    localparam int ACT_W   = 3;
    localparam int POS_W   = 4;
    localparam int HD_W    = 2;
    localparam int WALL_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] RST_MAZE_WIDTH  = 5'd16;
    localparam logic [SIZE_W-1:0] RST_MAZE_HEIGHT = 5'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 1'b1;

    // action codes, unused codes behave as a query
    localparam logic [ACT_W-1:0] ACT_DEFAULT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET_WALL  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET_VISIT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLR_VISIT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLR_ALL   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd5;

    // wall bits
    localparam int WB_N = 0;
    localparam int WB_E = 1;
    localparam int WB_S = 2;
    localparam int WB_W = 3;

    localparam logic [HD_W-1:0] HD_NORTH = 2'd0;
    localparam logic [HD_W-1:0] HD_EAST  = 2'd1;
    localparam logic [HD_W-1:0] HD_SOUTH = 2'd2;
    localparam logic [HD_W-1:0] HD_WEST  = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP_ALL,
        ST_SWEEP_VIS,
        ST_CHECK,
        ST_WALL_RD,
        ST_WALL_WC,
        ST_WALL_WN,
        ST_VIS_WR,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SWEEP_ALL,
        WR_SWEEP_VIS,
        WR_CELL_WALL,
        WR_NBR_WALL,
        WR_CELL_VIS
    } t_wr;

    typedef enum logic [1:0] {
        RD_CELL_N,
        RD_E_S,
        RD_W
    } t_rd;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_NBR,
        CAP_CELL,
        CAP_ES,
        CAP_W
    } t_cap;

    typedef struct packed {
        logic load_item;
        t_wr  wr;
        t_rd  rd;
        t_cap cap;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             bad;
        logic             sweep_last;
        logic             out_free;
    } t_stat;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] cell_x;
        logic [POS_W-1:0] cell_y;
        logic [HD_W-1:0]  heading;
    } t_item;

    typedef struct packed {
        logic              bad_cell;
        logic [WALL_W-1:0] walls;
        logic              seen;
        logic              north_open;
        logic              east_open;
        logic              south_open;
        logic              west_open;
    } t_result;

    // register value saturated to 1..maxv
    function automatic logic [COORD_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                    input logic [COORD_W-1:0] maxv);
        logic [COORD_W-1:0] ve;
        ve = COORD_W'(v);
        if (v == '0) begin
            return COORD_W'(1);
        end else if (ve > maxv) begin
            return maxv;
        end
        return ve;
    endfunction

endpackage

// ===== hdl/mwm_if.sv =====
interface mwm_in_if;
    logic                     valid;
    logic                     ready;
    logic [mwm_pkg::ACT_W-1:0] action;
    logic [mwm_pkg::POS_W-1:0] cell_x;
    logic [mwm_pkg::POS_W-1:0] cell_y;
    logic [mwm_pkg::HD_W-1:0]  heading;

    modport source (output valid, action, cell_x, cell_y, heading, input ready);
    modport sink   (input valid, action, cell_x, cell_y, heading, output ready);
endinterface

interface mwm_out_if;
    logic                       valid;
    logic                       ready;
    logic                       bad_cell;
    logic [mwm_pkg::WALL_W-1:0] walls;
    logic                       seen;
    logic                       north_open;
    logic                       east_open;
    logic                       south_open;
    logic                       west_open;

    modport source (output valid, bad_cell, walls, seen, north_open, east_open, south_open,
                    west_open, input ready);
    modport sink   (input valid, bad_cell, walls, seen, north_open, east_open, south_open,
                    west_open, output ready);
endinterface

interface mwm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mwm_pkg::CFG_IDX_W-1:0] index;
    logic [mwm_pkg::SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mwm_ram.sv =====
module mwm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/mwm_ctrl.sv =====
module mwm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mwm_pkg::t_stat i_stat,
    output mwm_pkg::t_cmd  o_cmd
);

    mwm_pkg::t_state r_state;
    mwm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwm_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.load_item = 1'b0;
        o_cmd.wr        = mwm_pkg::WR_NONE;
        o_cmd.rd        = mwm_pkg::RD_CELL_N;
        o_cmd.cap       = mwm_pkg::CAP_NONE;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            mwm_pkg::ST_INIT: begin
                // default map for the reset size
                o_cmd.wr = mwm_pkg::WR_SWEEP_ALL;
                if (i_stat.sweep_last) begin
                    n_state = mwm_pkg::ST_IDLE;
                end
            end
            mwm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = mwm_pkg::ST_DECODE;
                end
            end
            mwm_pkg::ST_DECODE: begin
                case (i_stat.act)
                    mwm_pkg::ACT_DEFAULT: n_state = mwm_pkg::ST_SWEEP_ALL;
                    mwm_pkg::ACT_CLR_ALL: n_state = mwm_pkg::ST_SWEEP_VIS;
                    default:              n_state = mwm_pkg::ST_CHECK;
                endcase
            end
            mwm_pkg::ST_SWEEP_ALL: begin
                o_cmd.wr = mwm_pkg::WR_SWEEP_ALL;
                if (i_stat.sweep_last) begin
                    n_state = mwm_pkg::ST_CHECK;
                end
            end
            mwm_pkg::ST_SWEEP_VIS: begin
                o_cmd.wr = mwm_pkg::WR_SWEEP_VIS;
                if (i_stat.sweep_last) begin
                    n_state = mwm_pkg::ST_CHECK;
                end
            end
            mwm_pkg::ST_CHECK: begin
                if (i_stat.bad) begin
                    n_state = mwm_pkg::ST_DONE;
                end else begin
                    case (i_stat.act) inside
                        mwm_pkg::ACT_SET_WALL:                         n_state = mwm_pkg::ST_WALL_RD;
                        mwm_pkg::ACT_SET_VISIT, mwm_pkg::ACT_CLR_VISIT: n_state = mwm_pkg::ST_VIS_WR;
                        default:                                       n_state = mwm_pkg::ST_Q0;
                    endcase
                end
            end
            mwm_pkg::ST_WALL_RD: begin
                n_state = mwm_pkg::ST_WALL_WC;
            end
            mwm_pkg::ST_WALL_WC: begin
                o_cmd.wr  = mwm_pkg::WR_CELL_WALL;
                o_cmd.cap = mwm_pkg::CAP_NBR;
                n_state   = mwm_pkg::ST_WALL_WN;
            end
            mwm_pkg::ST_WALL_WN: begin
                o_cmd.wr = mwm_pkg::WR_NBR_WALL;
                n_state  = mwm_pkg::ST_Q0;
            end
            mwm_pkg::ST_VIS_WR: begin
                o_cmd.wr = mwm_pkg::WR_CELL_VIS;
                n_state  = mwm_pkg::ST_Q0;
            end
            mwm_pkg::ST_Q0: begin
                o_cmd.rd = mwm_pkg::RD_CELL_N;
                n_state  = mwm_pkg::ST_Q1;
            end
            mwm_pkg::ST_Q1: begin
                o_cmd.cap = mwm_pkg::CAP_CELL;
                o_cmd.rd  = mwm_pkg::RD_E_S;
                n_state   = mwm_pkg::ST_Q2;
            end
            mwm_pkg::ST_Q2: begin
                o_cmd.cap = mwm_pkg::CAP_ES;
                o_cmd.rd  = mwm_pkg::RD_W;
                n_state   = mwm_pkg::ST_Q3;
            end
            mwm_pkg::ST_Q3: begin
                o_cmd.cap = mwm_pkg::CAP_W;
                n_state   = mwm_pkg::ST_DONE;
            end
            mwm_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = mwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mwm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mwm_dpath.sv =====
module mwm_dpath #(
    parameter int MAX_WIDTH  = mwm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mwm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mwm_pkg::SIZE_W-1:0]      i_cfg_data,
    input  mwm_pkg::t_item                  i_item,
    input  mwm_pkg::t_cmd                   i_cmd,
    output mwm_pkg::t_stat                  o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mwm_pkg::t_result                o_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XCW   = $clog2(MAX_WIDTH);
    localparam int YCW   = $clog2(MAX_HEIGHT);
    localparam int CW    = mwm_pkg::COORD_W;
    localparam int WW    = mwm_pkg::WALL_W;
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);

    localparam int WB_N = mwm_pkg::WB_N;
    localparam int WB_E = mwm_pkg::WB_E;
    localparam int WB_S = mwm_pkg::WB_S;
    localparam int WB_W = mwm_pkg::WB_W;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // configuration
    logic [mwm_pkg::SIZE_W-1:0] r_cfg_w;
    logic [mwm_pkg::SIZE_W-1:0] r_cfg_h;
    logic [CW-1:0]              eff_w;
    logic [CW-1:0]              eff_h;

    // item
    logic [mwm_pkg::ACT_W-1:0]  r_act;
    logic [CW-1:0]              r_x;
    logic [CW-1:0]              r_y;
    logic [mwm_pkg::HD_W-1:0]   r_hd;
    logic                       r_bad;
    logic [CW-1:0]              r_w;
    logic [CW-1:0]              r_h;
    logic [CW-1:0]              in_x;
    logic [CW-1:0]              in_y;

    // sweep
    logic [AW-1:0]              r_sw_addr;
    logic [XCW-1:0]             r_sw_x;
    logic [YCW-1:0]             r_sw_y;
    logic                       sw_step;
    logic                       sw_last;
    logic [CW-1:0]              sx;
    logic [CW-1:0]              sy;
    logic [WW-1:0]              dflt_walls;

    // neighbors
    logic                       n_ok;
    logic                       e_ok;
    logic                       s_ok;
    logic                       w_ok;
    logic [AW-1:0]              a_c;
    logic [AW-1:0]              a_n;
    logic [AW-1:0]              a_e;
    logic [AW-1:0]              a_s;
    logic [AW-1:0]              a_w;
    logic [AW-1:0]              a_nbr;
    logic                       nbr_ok;
    logic [mwm_pkg::HD_W-1:0]   opp_hd;

    // memories
    logic                       wall_we;
    logic [AW-1:0]              wall_waddr;
    logic [WW-1:0]              wall_wdata;
    logic [WW-1:0]              wall_rd_a;
    logic [WW-1:0]              wall_rd_b;
    logic                       vis_we;
    logic [AW-1:0]              vis_waddr;
    logic                       vis_wdata;
    logic [AW-1:0]              vis_ra;
    logic [AW-1:0]              vis_rb;
    logic                       vis_rd_a;
    logic                       vis_rd_b;

    // captured query data
    logic [WW-1:0]              r_nbr_walls;
    logic [WW-1:0]              r_wl;
    logic                       r_seen;
    logic                       r_vn;
    logic                       r_ve;
    logic                       r_vs;
    logic                       r_vw;

    logic                       r_out_valid;
    mwm_pkg::t_result           r_out;
    mwm_pkg::t_result           n_out;

    assign eff_w = mwm_pkg::eff_size(r_cfg_w, MAXW_C);
    assign eff_h = mwm_pkg::eff_size(r_cfg_h, MAXH_C);
    assign in_x  = CW'(i_item.cell_x);
    assign in_y  = CW'(i_item.cell_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= mwm_pkg::RST_MAZE_WIDTH;
            r_cfg_h <= mwm_pkg::RST_MAZE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mwm_pkg::CFG_MAZE_WIDTH:  r_cfg_w <= i_cfg_data;
                mwm_pkg::CFG_MAZE_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sizes seen by the reset sweep, then latched with each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= mwm_pkg::eff_size(mwm_pkg::RST_MAZE_WIDTH, MAXW_C);
            r_h <= mwm_pkg::eff_size(mwm_pkg::RST_MAZE_HEIGHT, MAXH_C);
        end else if (i_cmd.load_item) begin
            r_w <= eff_w;
            r_h <= eff_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_act <= i_item.action;
            r_x   <= in_x;
            r_y   <= in_y;
            r_hd  <= i_item.heading;
            r_bad <= (in_x >= eff_w) || (in_y >= eff_h);
        end
    end

    // sweep counters wrap to zero after the last entry
    assign sw_step = (i_cmd.wr == mwm_pkg::WR_SWEEP_ALL) || (i_cmd.wr == mwm_pkg::WR_SWEEP_VIS);
    assign sw_last = (r_sw_addr == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_addr <= '0;
            r_sw_x    <= '0;
            r_sw_y    <= '0;
        end else if (sw_step) begin
            if (sw_last) begin
                r_sw_addr <= '0;
                r_sw_x    <= '0;
                r_sw_y    <= '0;
            end else begin
                r_sw_addr <= r_sw_addr + AW'(1);
                if (r_sw_x == XCW'(MAX_WIDTH - 1)) begin
                    r_sw_x <= '0;
                    r_sw_y <= r_sw_y + YCW'(1);
                end else begin
                    r_sw_x <= r_sw_x + XCW'(1);
                end
            end
        end
    end

    assign sx = CW'(r_sw_x);
    assign sy = CW'(r_sw_y);

    always_comb begin
        dflt_walls       = '0;
        dflt_walls[WB_N] = (sy == r_h - CW'(1)) && (sx < r_w);
        dflt_walls[WB_S] = (sy == '0) && (sx < r_w);
        dflt_walls[WB_E] = ((sx == r_w - CW'(1)) && (sy < r_h)) || ((sx == '0) && (sy == '0));
        dflt_walls[WB_W] = (sx == '0) && (sy < r_h);
    end

    // out of range neighbors fall back to the cell itself
    assign n_ok = (r_y + CW'(1)) < r_h;
    assign e_ok = (r_x + CW'(1)) < r_w;
    assign s_ok = (r_y != '0);
    assign w_ok = (r_x != '0);
    assign a_c  = cell_addr(r_x, r_y);
    assign a_n  = n_ok ? cell_addr(r_x, r_y + CW'(1)) : a_c;
    assign a_e  = e_ok ? cell_addr(r_x + CW'(1), r_y) : a_c;
    assign a_s  = s_ok ? cell_addr(r_x, r_y - CW'(1)) : a_c;
    assign a_w  = w_ok ? cell_addr(r_x - CW'(1), r_y) : a_c;
    assign opp_hd = r_hd ^ mwm_pkg::HD_SOUTH;

    always_comb begin
        case (r_hd)
            mwm_pkg::HD_NORTH: begin a_nbr = a_n; nbr_ok = n_ok; end
            mwm_pkg::HD_EAST:  begin a_nbr = a_e; nbr_ok = e_ok; end
            mwm_pkg::HD_SOUTH: begin a_nbr = a_s; nbr_ok = s_ok; end
            default:           begin a_nbr = a_w; nbr_ok = w_ok; end
        endcase
    end

    always_comb begin
        wall_we    = 1'b0;
        wall_waddr = a_c;
        wall_wdata = dflt_walls;
        vis_we     = 1'b0;
        vis_waddr  = a_c;
        vis_wdata  = 1'b0;
        unique case (i_cmd.wr)
            mwm_pkg::WR_NONE: ;
            mwm_pkg::WR_SWEEP_ALL: begin
                wall_we    = 1'b1;
                wall_waddr = r_sw_addr;
                wall_wdata = dflt_walls;
                vis_we     = 1'b1;
                vis_waddr  = r_sw_addr;
            end
            mwm_pkg::WR_SWEEP_VIS: begin
                vis_we    = 1'b1;
                vis_waddr = r_sw_addr;
            end
            mwm_pkg::WR_CELL_WALL: begin
                wall_we    = 1'b1;
                wall_wdata = wall_rd_a | (WW'(1) << r_hd);
            end
            mwm_pkg::WR_NBR_WALL: begin
                wall_we    = nbr_ok;
                wall_waddr = a_nbr;
                wall_wdata = r_nbr_walls | (WW'(1) << opp_hd);
            end
            mwm_pkg::WR_CELL_VIS: begin
                vis_we    = 1'b1;
                vis_wdata = (r_act == mwm_pkg::ACT_SET_VISIT);
            end
            default: ;
        endcase
    end

    always_comb begin
        vis_ra = a_c;
        vis_rb = a_n;
        unique case (i_cmd.rd)
            mwm_pkg::RD_CELL_N: begin vis_ra = a_c; vis_rb = a_n; end
            mwm_pkg::RD_E_S:    begin vis_ra = a_e; vis_rb = a_s; end
            mwm_pkg::RD_W:      begin vis_ra = a_w; vis_rb = a_w; end
            default: ;
        endcase
    end

    mwm_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_wall_ram (
        .i_clk     (i_clk),
        .i_we      (wall_we),
        .i_waddr   (wall_waddr),
        .i_wdata   (wall_wdata),
        .i_raddr_a (a_c),
        .i_raddr_b (a_nbr),
        .o_rdata_a (wall_rd_a),
        .o_rdata_b (wall_rd_b)
    );

    mwm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_vis_ram (
        .i_clk     (i_clk),
        .i_we      (vis_we),
        .i_waddr   (vis_waddr),
        .i_wdata   (vis_wdata),
        .i_raddr_a (vis_ra),
        .i_raddr_b (vis_rb),
        .o_rdata_a (vis_rd_a),
        .o_rdata_b (vis_rd_b)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cap)
            mwm_pkg::CAP_NONE: ;
            mwm_pkg::CAP_NBR:  r_nbr_walls <= wall_rd_b;
            mwm_pkg::CAP_CELL: begin
                r_wl   <= wall_rd_a;
                r_seen <= vis_rd_a;
                r_vn   <= vis_rd_b;
            end
            mwm_pkg::CAP_ES: begin
                r_ve <= vis_rd_a;
                r_vs <= vis_rd_b;
            end
            mwm_pkg::CAP_W:    r_vw <= vis_rd_a;
            default: ;
        endcase
    end

    always_comb begin
        n_out = '0;
        if (r_bad) begin
            n_out.bad_cell = 1'b1;
        end else begin
            n_out.walls      = r_wl;
            n_out.seen       = r_seen;
            n_out.north_open = n_ok && !r_wl[WB_N] && !r_vn;
            n_out.east_open  = e_ok && !r_wl[WB_E] && !r_ve;
            n_out.south_open = s_ok && !r_wl[WB_S] && !r_vs;
            n_out.west_open  = w_ok && !r_wl[WB_W] && !r_vw;
        end
    end

    // result register, frees the item side while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;
    assign o_stat.act        = r_act;
    assign o_stat.bad        = r_bad;
    assign o_stat.sweep_last = sw_last;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

// ===== hdl/maze_wall_map.sv =====
// query and unused codes pass DECODE, CHECK, Q0 to Q3 and DONE, which loads the result; a new
// beat is taken back in IDLE. a cell outside the maze skips Q0 to Q3. set wall adds WALL_RD,
// WALL_WC and WALL_WN, set or clear visited adds VIS_WR; rebuild and clear all visited add a
// sweep over all MAX_WIDTH * MAX_HEIGHT cells, one cell a cycle. a waiting result sits in an
// output register, so the next beat is taken meanwhile. reset: config returns to 16 x 16, then
// a sweep writes the default map before the first input beat; config writes are taken during it
module maze_wall_map #(
    parameter int MAX_WIDTH  = mwm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mwm_pkg::MAX_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mwm_in_if.sink     i_item,
    mwm_out_if.source  o_result,
    mwm_cfg_if.sink    i_cfg
);

    mwm_pkg::t_cmd    cmd;
    mwm_pkg::t_stat   stat;
    mwm_pkg::t_item   item;
    mwm_pkg::t_result res;
    logic             in_ready;
    logic             out_valid;

    assign item.action  = i_item.action;
    assign item.cell_x  = i_item.cell_x;
    assign item.cell_y  = i_item.cell_y;
    assign item.heading = i_item.heading;
    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    mwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mwm_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_out       (res)
    );

    assign o_result.valid      = out_valid;
    assign o_result.bad_cell   = res.bad_cell;
    assign o_result.walls      = res.walls;
    assign o_result.seen       = res.seen;
    assign o_result.north_open = res.north_open;
    assign o_result.east_open  = res.east_open;
    assign o_result.south_open = res.south_open;
    assign o_result.west_open  = res.west_open;

endmodule

// ===== verif/maze_map_checker.sv =====
`timescale 1ns / 1ps

module maze_map_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mwm_in_if    i_item,
    mwm_out_if   i_result,
    mwm_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import mwm_pkg::*;

    localparam int GRID_W = MAX_WIDTH_DEF;
    localparam int GRID_H = MAX_HEIGHT_DEF;

    bit [WALL_W-1:0]   wall_map  [GRID_H][GRID_W];
    bit                visit_map [GRID_H][GRID_W];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    t_result           cell_report_q[$];
    int                mismatches;

    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
        if (v == '0) begin
            return 1;
        end else if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic void clear_visits();
        foreach (visit_map[r, c]) begin
            visit_map[r][c] = 1'b0;
        end
    endfunction

    function automatic void rebuild_map();
        int w;
        int h;
        w = clamp_size(width_reg, GRID_W);
        h = clamp_size(height_reg, GRID_H);
        foreach (wall_map[r, c]) begin
            wall_map[r][c] = '0;
        end
        clear_visits();
        for (int i = 0; i < w; i++) begin
            wall_map[h-1][i][WB_N] = 1'b1;
            wall_map[0][i][WB_S]   = 1'b1;
        end
        for (int i = 0; i < h; i++) begin
            wall_map[i][w-1][WB_E] = 1'b1;
            wall_map[i][0][WB_W]   = 1'b1;
        end
        // the start cell always gets its east wall
        wall_map[0][0][WB_E] = 1'b1;
    endfunction

    // performs one action on the map and reports the addressed cell afterwards
    function automatic t_result apply_action(input t_item it);
        int                w;
        int                h;
        int                x;
        int                y;
        logic [WALL_W-1:0] wl;
        t_result           r;
        w = clamp_size(width_reg, GRID_W);
        h = clamp_size(height_reg, GRID_H);
        x = int'(it.cell_x);
        y = int'(it.cell_y);
        r = '0;
        // map-wide actions run even for a cell outside the maze
        if (it.action == ACT_DEFAULT) begin
            rebuild_map();
        end else if (it.action == ACT_CLR_ALL) begin
            clear_visits();
        end
        if (x >= w || y >= h) begin
            r.bad_cell = 1'b1;
            return r;
        end
        case (it.action)
            ACT_SET_WALL: begin
                case (it.heading)
                    HD_NORTH: begin
                        wall_map[y][x][WB_N] = 1'b1;
                        if (y + 1 < h) wall_map[y+1][x][WB_S] = 1'b1;
                    end
                    HD_EAST: begin
                        wall_map[y][x][WB_E] = 1'b1;
                        if (x + 1 < w) wall_map[y][x+1][WB_W] = 1'b1;
                    end
                    HD_SOUTH: begin
                        wall_map[y][x][WB_S] = 1'b1;
                        if (y > 0) wall_map[y-1][x][WB_N] = 1'b1;
                    end
                    default: begin
                        wall_map[y][x][WB_W] = 1'b1;
                        if (x > 0) wall_map[y][x-1][WB_E] = 1'b1;
                    end
                endcase
            end
            ACT_SET_VISIT: begin
                visit_map[y][x] = 1'b1;
            end
            ACT_CLR_VISIT: begin
                visit_map[y][x] = 1'b0;
            end
            default: ;
        endcase
        wl = wall_map[y][x];
        r.walls      = wl;
        r.seen       = visit_map[y][x];
        r.north_open = (y + 1 < h) && !wl[WB_N] && !visit_map[y+1][x];
        r.east_open  = (x + 1 < w) && !wl[WB_E] && !visit_map[y][x+1];
        r.south_open = (y > 0) && !wl[WB_S] && !visit_map[y-1][x];
        r.west_open  = (x > 0) && !wl[WB_W] && !visit_map[y][x-1];
        return r;
    endfunction

    function automatic void report_result(input string what, input t_result want,
                                          input t_result got);
        if (mismatches < 10) begin
            $display("%0t: %s: expected bad=%0d walls=%h seen=%0d nesw=%b%b%b%b",
                     $time, what, want.bad_cell, want.walls, want.seen, want.north_open,
                     want.east_open, want.south_open, want.west_open,
                     ", got bad=%0d walls=%h seen=%0d nesw=%b%b%b%b", got.bad_cell,
                     got.walls, got.seen, got.north_open, got.east_open, got.south_open,
                     got.west_open);
        end
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            width_reg  = RST_MAZE_WIDTH;
            height_reg = RST_MAZE_HEIGHT;
            rebuild_map();
            cell_report_q.delete();
            mismatches = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = '{bad_cell: i_result.bad_cell, walls: i_result.walls,
                        seen: i_result.seen, north_open: i_result.north_open,
                        east_open: i_result.east_open, south_open: i_result.south_open,
                        west_open: i_result.west_open};
                if (cell_report_q.size() == 0) begin
                    report_result("unexpected result beat", '0, got);
                end else begin
                    want = cell_report_q.pop_front();
                    if (got.bad_cell !== want.bad_cell || got.walls !== want.walls ||
                        got.seen !== want.seen || got.north_open !== want.north_open ||
                        got.east_open !== want.east_open ||
                        got.south_open !== want.south_open ||
                        got.west_open !== want.west_open) begin
                        report_result("result mismatch", want, got);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_MAZE_WIDTH) begin
                    width_reg = i_cfg.data;
                end else if (i_cfg.index == CFG_MAZE_HEIGHT) begin
                    height_reg = i_cfg.data;
                end
            end
            if (i_item.valid && i_item.ready) begin
                cell_report_q.push_back(apply_action('{action: i_item.action,
                                                       cell_x: i_item.cell_x,
                                                       cell_y: i_item.cell_y,
                                                       heading: i_item.heading}));
            end
        end
        o_pending    <= cell_report_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/maze_wall_map_tb.sv =====
`timescale 1ns / 1ps

module maze_wall_map_tb;
    import mwm_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int TIMEOUT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 300;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int GRID_W          = MAX_WIDTH_DEF;
    localparam int GRID_H          = MAX_HEIGHT_DEF;

    // spare action codes, the block treats them as a query
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cur_w;
    int   cur_h;
    int   last_x;
    int   last_y;

    mwm_in_if  item_ch ();
    mwm_out_if result_ch ();
    mwm_cfg_if cfg_ch ();

    maze_wall_map uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    maze_map_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [HD_W-1:0] hd);
        if ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= act;
        item_ch.cell_x  <= x;
        item_ch.cell_y  <= y;
        item_ch.heading <= hd;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // stop sending and wait until every reported cell is back and the block is quiet
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic resize_maze(input int w, input int h);
        drain_results();
        write_reg(CFG_MAZE_WIDTH, SIZE_W'(w));
        write_reg(CFG_MAZE_HEIGHT, SIZE_W'(h));
        cur_w = (w == 0) ? 1 : ((w > GRID_W) ? GRID_W : w);
        cur_h = (h == 0) ? 1 : ((h > GRID_H) ? GRID_H : h);
    endtask

    task automatic random_item();
        int               pick;
        int               x;
        int               y;
        logic [ACT_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < 2) begin
            act = ACT_DEFAULT;
        end else if (pick < 5) begin
            act = ACT_CLR_ALL;
        end else if (pick < 30) begin
            act = ACT_SET_WALL;
        end else if (pick < 50) begin
            act = ACT_SET_VISIT;
        end else if (pick < 58) begin
            act = ACT_CLR_VISIT;
        end else if (pick < 95) begin
            act = ACT_QUERY;
        end else begin
            act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        end
        // half the time step around the last cell so shared walls and visited neighbours interact
        pick = $urandom_range(99);
        if (pick < 50) begin
            x = last_x + int'($urandom_range(2)) - 1;
            y = last_y + int'($urandom_range(2)) - 1;
            if (x < 0) x = 0;
            if (y < 0) y = 0;
            if (x >= cur_w) x = cur_w - 1;
            if (y >= cur_h) y = cur_h - 1;
        end else if (pick < 88) begin
            x = $urandom_range(cur_w - 1);
            y = $urandom_range(cur_h - 1);
        end else begin
            x = $urandom_range(GRID_W - 1);
            y = $urandom_range(GRID_H - 1);
        end
        last_x = x;
        last_y = y;
        send_item(act, POS_W'(x), POS_W'(y), HD_W'($urandom_range(3)));
    endtask

    initial begin
        int phase_w[N_PHASES];
        int phase_h[N_PHASES];
        phase_w = '{16, 0, 31, 1, 17, 7, 2, 16};
        phase_h = '{16, 31, 0, 1, 16, 12, 16, 2};
        item_ch.valid   = 1'b0;
        item_ch.action  = ACT_QUERY;
        item_ch.cell_x  = '0;
        item_ch.cell_y  = '0;
        item_ch.heading = HD_NORTH;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_MAZE_WIDTH;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        cur_w           = GRID_W;
        cur_h           = GRID_H;
        last_x          = 0;
        last_y          = 0;
        i_rst_n         = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // the reset sweep builds the map before the first beat is taken
        while (!item_ch.ready) @(posedge i_clk);

        // default 16 x 16 map straight out of reset
        send_item(ACT_QUERY, 4'd0, 4'd0, HD_NORTH);
        send_item(ACT_QUERY, 4'd15, 4'd15, HD_WEST);
        send_item(ACT_SPARE_LO, 4'd15, 4'd0, HD_EAST);
        send_item(ACT_SPARE_HI, 4'd0, 4'd15, HD_SOUTH);
        send_item(ACT_SET_WALL, 4'd5, 4'd5, HD_NORTH);
        send_item(ACT_SET_WALL, 4'd5, 4'd5, HD_EAST);
        send_item(ACT_SET_WALL, 4'd5, 4'd5, HD_SOUTH);
        send_item(ACT_SET_WALL, 4'd5, 4'd5, HD_WEST);
        send_item(ACT_QUERY, 4'd5, 4'd6, HD_NORTH);
        send_item(ACT_SET_VISIT, 4'd9, 4'd10, HD_NORTH);
        send_item(ACT_SET_VISIT, 4'd10, 4'd9, HD_NORTH);
        send_item(ACT_QUERY, 4'd9, 4'd9, HD_NORTH);
        send_item(ACT_CLR_VISIT, 4'd9, 4'd10, HD_NORTH);
        send_item(ACT_SET_VISIT, 4'd9, 4'd9, HD_NORTH);
        send_item(ACT_CLR_ALL, 4'd9, 4'd9, HD_NORTH);
        // walls on the border have no neighbour to mirror into
        send_item(ACT_SET_WALL, 4'd0, 4'd0, HD_WEST);
        send_item(ACT_SET_WALL, 4'd15, 4'd15, HD_NORTH);
        send_item(ACT_SET_WALL, 4'd7, 4'd0, HD_SOUTH);
        send_item(ACT_DEFAULT, 4'd2, 4'd2, HD_EAST);

        // small maze: cells outside it are flagged, map-wide actions still run
        resize_maze(5, 3);
        send_item(ACT_SET_WALL, 4'd4, 4'd1, HD_EAST);
        send_item(ACT_SET_WALL, 4'd7, 4'd1, HD_NORTH);
        send_item(ACT_SET_VISIT, 4'd1, 4'd9, HD_NORTH);
        send_item(ACT_CLR_VISIT, 4'd15, 4'd15, HD_NORTH);
        send_item(ACT_SET_VISIT, 4'd4, 4'd2, HD_NORTH);
        send_item(ACT_CLR_ALL, 4'd9, 4'd9, HD_NORTH);
        send_item(ACT_QUERY, 4'd4, 4'd2, HD_NORTH);
        send_item(ACT_DEFAULT, 4'd5, 4'd2, HD_NORTH);
        send_item(ACT_QUERY, 4'd4, 4'd2, HD_NORTH);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            if (phase == N_PHASES - 1) begin
                resize_maze($urandom_range(31), $urandom_range(31));
            end else begin
                resize_maze(phase_w[phase], phase_h[phase]);
            end
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            // each phase rebuilds the map only on a coin flip, so stale walls outside the new size show up
            if ($urandom_range(1)) begin
                send_item(ACT_DEFAULT, 4'd0, 4'd0, HD_NORTH);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 0) begin
                    drain_results();
                end
                random_item();
            end
        end

        drain_results();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
